### hdl/stcr_pkg.sv
// Shared types, constants and helpers for the servo telemetry range capture block.
`timescale 1ns / 1ps

package stcr_pkg;

   // Sizes fixed by the record format
   localparam int SERVO_COUNT_DEF = 6;
   localparam int LIM_W           = 12;
   localparam int ID_W            = 9;
   localparam int POS_W           = 13;
   localparam int SRV_W           = 3;
   localparam int DIG_W           = 4;

   localparam logic [LIM_W-1:0] POS_MAX = LIM_W'(4095);
   localparam logic [ID_W-1:0]  ID_SAT  = ID_W'(511);
   localparam logic [POS_W-1:0] POS_SAT = POS_W'(8191);

   // Request codes
   localparam logic [1:0] REQ_TEXT = 2'd0;
   localparam logic [1:0] REQ_LOAD = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   // Characters of the record format
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef enum logic [2:0] {
      PH_SEEK,
      PH_ID_LEAD,
      PH_ID_SIGN,
      PH_ID_DIG,
      PH_GAP,
      PH_POS_LEAD,
      PH_POS_SIGN,
      PH_POS_DIG
   } phase_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [7:0]       text_byte;
      logic             last_byte;
      logic [SRV_W-1:0] entry_servo;
      logic [LIM_W-1:0] entry_low_limit;
      logic [LIM_W-1:0] entry_high_limit;
   } req_item_type;

   typedef struct packed {
      logic             record_committed;
      logic             text_done;
      logic             is_readback;
      logic [SRV_W-1:0] servo_number;
      logic [LIM_W-1:0] low_limit;
      logic [LIM_W-1:0] high_limit;
      logic             any_updated;
   } rsp_item_type;

   // Parser verdict for one text byte
   typedef struct packed {
      logic             commit_ok;
      logic [ID_W-1:0]  commit_id;
      logic [LIM_W-1:0] commit_pos;
      logic             ended;
      logic             any_updated;
   } parse_out_type;

   // Decimal accumulate with saturation
   function automatic logic [POS_W-1:0] sat_acc(input logic [POS_W-1:0] acc,
                                                input logic [DIG_W-1:0] dig,
                                                input logic [POS_W-1:0] limit);
      logic [POS_W+3:0] v;
      v = {4'b0, acc} * (POS_W+4)'(10) + (POS_W+4)'(dig);
      return (v > {4'b0, limit}) ? limit : v[POS_W-1:0];
   endfunction

endpackage

### hdl/stcr_parser.sv
// Record parser: phase machine, id and position accumulators, commit decision.
`timescale 1ns / 1ps

module stcr_parser import stcr_pkg::*; #(
   parameter int SERVO_COUNT = SERVO_COUNT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    text_byte,
   input  logic          last_byte,
   output parse_out_type parse_out
);

   phase_type        phase_ff, phase_in, phase_pre;
   logic [ID_W-1:0]  id_acc_ff, id_acc_in, id_acc_pre;
   logic             id_neg_ff, id_neg_in, id_neg_pre;
   logic [POS_W-1:0] pos_acc_ff, pos_acc_in, pos_acc_pre;
   logic             pos_neg_ff, pos_neg_in, pos_neg_pre;
   logic             updated_ff, updated_in;

   logic             is_nul, is_digit, is_ws, is_hash, is_sign, is_minus, is_p;
   logic [DIG_W-1:0] dig;
   logic             ended, first_commit, second_commit, commit;
   logic [ID_W-1:0]  c_id;
   logic             c_id_neg, c_pos_neg, c_valid;
   logic [POS_W-1:0] c_pos;

   // Character classes
   assign is_nul   = (text_byte == CH_NUL);
   assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
   assign is_ws    = (text_byte == CH_SPACE) || ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
   assign is_hash  = (text_byte == CH_HASH);
   assign is_minus = (text_byte == CH_MINUS);
   assign is_sign  = (text_byte == CH_PLUS) || is_minus;
   assign is_p     = (text_byte == CH_P);
   assign dig      = text_byte[DIG_W-1:0];
   assign ended    = is_nul || last_byte;

   // Next phase
   always_comb begin
      phase_pre = phase_ff;
      if (is_nul) begin
         phase_pre = phase_ff;
      end else if ((phase_ff == PH_POS_DIG) && is_digit) begin
         phase_pre = PH_POS_DIG;
      end else if (is_hash) begin
         phase_pre = PH_ID_LEAD;
      end else begin
         unique case (phase_ff)
            PH_SEEK, PH_POS_DIG: phase_pre = PH_SEEK;
            PH_ID_LEAD: begin
               if (is_ws)         phase_pre = PH_ID_LEAD;
               else if (is_sign)  phase_pre = PH_ID_SIGN;
               else if (is_digit) phase_pre = PH_ID_DIG;
               else               phase_pre = PH_SEEK;
            end
            PH_ID_SIGN: phase_pre = is_digit ? PH_ID_DIG : PH_SEEK;
            PH_ID_DIG: begin
               if (is_digit)   phase_pre = PH_ID_DIG;
               else if (is_ws) phase_pre = PH_GAP;
               else if (is_p)  phase_pre = PH_POS_LEAD;
               else            phase_pre = PH_SEEK;
            end
            PH_GAP: begin
               if (is_p)       phase_pre = PH_POS_LEAD;
               else if (is_ws) phase_pre = PH_GAP;
               else            phase_pre = PH_SEEK;
            end
            PH_POS_LEAD: begin
               if (is_ws)         phase_pre = PH_POS_LEAD;
               else if (is_sign)  phase_pre = PH_POS_SIGN;
               else if (is_digit) phase_pre = PH_POS_DIG;
               else               phase_pre = PH_SEEK;
            end
            PH_POS_SIGN: phase_pre = is_digit ? PH_POS_DIG : PH_SEEK;
            default:     phase_pre = PH_SEEK;
         endcase
      end
      phase_in = ended ? PH_SEEK : phase_pre;
   end

   // Accumulators, commit and outputs
   always_comb begin
      id_acc_pre  = id_acc_ff;
      id_neg_pre  = id_neg_ff;
      pos_acc_pre = pos_acc_ff;
      pos_neg_pre = pos_neg_ff;
      if (is_nul) begin
         // no character to take in
      end else if ((phase_ff == PH_POS_DIG) && is_digit) begin
         pos_acc_pre = sat_acc(pos_acc_ff, dig, POS_SAT);
      end else if (is_hash) begin
         id_acc_pre  = '0;
         id_neg_pre  = 1'b0;
         pos_acc_pre = '0;
         pos_neg_pre = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_ID_LEAD: begin
               if (is_sign)       id_neg_pre = is_minus;
               else if (is_digit) id_acc_pre = ID_W'(dig);
            end
            PH_ID_SIGN: begin
               if (is_digit) id_acc_pre = ID_W'(dig);
            end
            PH_ID_DIG: begin
               if (is_digit) id_acc_pre = ID_W'(sat_acc(POS_W'(id_acc_ff), dig, POS_W'(ID_SAT)));
            end
            PH_POS_LEAD: begin
               if (is_sign)       pos_neg_pre = is_minus;
               else if (is_digit) pos_acc_pre = POS_W'(dig);
            end
            PH_POS_SIGN: begin
               if (is_digit) pos_acc_pre = POS_W'(dig);
            end
            default: ;
         endcase
      end

      // a non-digit closes a pending position; text end closes one too
      first_commit  = !is_nul && (phase_ff == PH_POS_DIG) && !is_digit;
      second_commit = ended && (phase_pre == PH_POS_DIG);
      commit        = first_commit || second_commit;
      c_id      = first_commit ? id_acc_ff  : id_acc_pre;
      c_id_neg  = first_commit ? id_neg_ff  : id_neg_pre;
      c_pos     = first_commit ? pos_acc_ff : pos_acc_pre;
      c_pos_neg = first_commit ? pos_neg_ff : pos_neg_pre;
      c_valid   = commit && !c_id_neg && (c_id != '0) && (c_id <= ID_W'(SERVO_COUNT));

      parse_out.commit_ok   = c_valid;
      parse_out.commit_id   = c_id;
      if (c_pos_neg)                        parse_out.commit_pos = '0;
      else if (c_pos > POS_W'(POS_MAX))     parse_out.commit_pos = POS_MAX;
      else                                  parse_out.commit_pos = c_pos[LIM_W-1:0];
      parse_out.ended       = ended;
      parse_out.any_updated = updated_ff || c_valid;

      id_acc_in  = ended ? '0   : id_acc_pre;
      id_neg_in  = ended ? 1'b0 : id_neg_pre;
      pos_acc_in = ended ? '0   : pos_acc_pre;
      pos_neg_in = ended ? 1'b0 : pos_neg_pre;
      updated_in = ended ? 1'b0 : (updated_ff || c_valid);
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SEEK;
         id_acc_ff  <= '0;
         id_neg_ff  <= 1'b0;
         pos_acc_ff <= '0;
         pos_neg_ff <= 1'b0;
         updated_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         id_acc_ff  <= id_acc_in;
         id_neg_ff  <= id_neg_in;
         pos_acc_ff <= pos_acc_in;
         pos_neg_ff <= pos_neg_in;
         updated_ff <= updated_in;
      end
   end

endmodule

### hdl/servo_telemetry_range_capture.sv
// Top level: parser front end, limit table memory with write-back stage, result register.
// Path: the table read is registered with stage one, then the updated entry in the result register.
// Throughput: one request per cycle unless a stalled result holds stage one; table read at
// transfer, write-back as stage one advances, last write forwarded to a same-servo next request.
// Reset (synchronous): parser returns to hash search, every table entry reads as zero
// through per-entry valid bits, capture_mode returns to 1, no result is pending.
`timescale 1ns / 1ps

module servo_telemetry_range_capture import stcr_pkg::*; #(
   parameter int SERVO_COUNT = SERVO_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_payload,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
   localparam int ENT_W = 2 * LIM_W;

   // Stage-one contents
   typedef struct packed {
      logic             is_load;
      logic             is_read;
      logic             wr;
      logic             has_result;
      logic             committed;
      logic             ended;
      logic             any_updated;
      logic             entry_ok;
      logic             mode;
      logic [SRV_W-1:0] servo;
      logic [IDX_W-1:0] addr;
      logic [LIM_W-1:0] pos;
      logic [LIM_W-1:0] load_lo;
      logic [LIM_W-1:0] load_hi;
   } stage_type;

   logic             mode_ff;
   logic             req_fire, s1_adv, s1_fire;
   logic             s1_valid_ff, s1_valid_in;
   stage_type        s1_ff, s1_in;
   parse_out_type    parse_out;
   logic             entry_ok;
   logic [ID_W-1:0]  servo_ext;

   logic [ENT_W-1:0] mem [SERVO_COUNT];
   logic [SERVO_COUNT-1:0] ent_vld_ff;
   logic [ENT_W-1:0] rd_data_ff;
   logic             rd_vld_ff;
   logic             fwd_vld_ff;
   logic [IDX_W-1:0] fwd_addr_ff;
   logic [ENT_W-1:0] fwd_data_ff;

   logic [LIM_W-1:0] cur_lo, cur_hi, new_lo, new_hi;
   logic             wr_fire;
   logic [ENT_W-1:0] wr_data;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;

   // Handshake
   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && s1_adv;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_fire  = req_valid && !req_stall;

   // Capture mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   stcr_parser #(.SERVO_COUNT(SERVO_COUNT)) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (req_fire && (req_payload.req_type == REQ_TEXT)),
      .text_byte (req_payload.text_byte),
      .last_byte (req_payload.last_byte),
      .parse_out (parse_out)
   );

   // Decode the request into stage-one work
   assign servo_ext = ID_W'(req_payload.entry_servo);
   assign entry_ok  = (servo_ext != '0) && (servo_ext <= ID_W'(SERVO_COUNT));

   always_comb begin
      s1_in             = '0;
      s1_in.mode        = mode_ff;
      s1_in.load_lo     = req_payload.entry_low_limit;
      s1_in.load_hi     = req_payload.entry_high_limit;
      s1_in.entry_ok    = entry_ok;
      unique case (req_payload.req_type)
         REQ_TEXT: begin
            s1_in.wr          = parse_out.commit_ok;
            s1_in.committed   = parse_out.commit_ok;
            s1_in.ended       = parse_out.ended;
            s1_in.any_updated = parse_out.ended && parse_out.any_updated;
            s1_in.has_result  = parse_out.commit_ok || parse_out.ended;
            s1_in.pos         = parse_out.commit_pos;
            if (parse_out.commit_ok) begin
               s1_in.servo = parse_out.commit_id[SRV_W-1:0];
               s1_in.addr  = IDX_W'(parse_out.commit_id - ID_W'(1));
            end
         end
         REQ_LOAD: begin
            s1_in.is_load = 1'b1;
            s1_in.wr      = entry_ok;
            if (entry_ok) s1_in.addr = IDX_W'(servo_ext - ID_W'(1));
         end
         REQ_READ: begin
            s1_in.is_read    = 1'b1;
            s1_in.has_result = 1'b1;
            if (entry_ok) begin
               s1_in.servo = req_payload.entry_servo;
               s1_in.addr  = IDX_W'(servo_ext - ID_W'(1));
            end
         end
         default: ;
      endcase
   end

   // Stage one register
   assign s1_valid_in = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
   end

   // Table read at transfer, last write captured alongside for forwarding
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff  <= mem[s1_in.addr];
         rd_vld_ff   <= ent_vld_ff[s1_in.addr];
         fwd_addr_ff <= s1_ff.addr;
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
      end else if (req_fire) begin
         fwd_vld_ff <= wr_fire;
      end
   end

   // Current entry: forwarded write, stored value, or zero if never written
   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == s1_ff.addr)) begin
         {cur_lo, cur_hi} = fwd_data_ff;
      end else if (rd_vld_ff) begin
         {cur_lo, cur_hi} = rd_data_ff;
      end else begin
         cur_lo = '0;
         cur_hi = '0;
      end
   end

   // Modify
   always_comb begin
      new_lo = cur_lo;
      new_hi = cur_hi;
      if (s1_ff.is_load) begin
         new_lo = s1_ff.load_lo;
         new_hi = s1_ff.load_hi;
      end else if (s1_ff.committed) begin
         if (s1_ff.mode) begin
            new_lo = s1_ff.pos;
            if (cur_hi < s1_ff.pos) new_hi = s1_ff.pos;
         end else begin
            new_hi = s1_ff.pos;
            if (cur_lo > s1_ff.pos) new_lo = s1_ff.pos;
         end
      end
   end

   assign wr_fire = s1_fire && s1_ff.wr;
   assign wr_data = {new_lo, new_hi};

   // Write back
   always_ff @(posedge clock) begin
      if (wr_fire) begin
         mem[s1_ff.addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= '0;
      end else if (wr_fire) begin
         ent_vld_ff[s1_ff.addr] <= 1'b1;
      end
   end

   // Result
   always_comb begin
      rsp_in                  = '0;
      rsp_in.record_committed = s1_ff.committed;
      rsp_in.text_done        = s1_ff.ended;
      rsp_in.is_readback      = s1_ff.is_read;
      rsp_in.any_updated      = s1_ff.any_updated;
      rsp_in.servo_number     = s1_ff.servo;
      if (s1_ff.committed) begin
         rsp_in.low_limit  = new_lo;
         rsp_in.high_limit = new_hi;
      end else if (s1_ff.is_read && s1_ff.entry_ok) begin
         rsp_in.low_limit  = cur_lo;
         rsp_in.high_limit = cur_hi;
      end
   end

   assign rsp_valid_in = s1_fire ? s1_ff.has_result : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### hdl/stcr_checker.sv
// Port-level checks for the range capture block, bound to the top level.
`timescale 1ns / 1ps

module stcr_checker import stcr_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_payload
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // Nothing pending after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A readback carries no parser flags
   a_readback_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_readback |->
         !rsp_payload.record_committed && !rsp_payload.text_done && !rsp_payload.any_updated)
      else $error("readback with parser flags");

   // A commit always leaves the entry ordered
   a_commit_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.record_committed |->
         rsp_payload.low_limit <= rsp_payload.high_limit)
      else $error("committed entry out of order");

   // The update summary only comes with text end
   a_updated_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.any_updated |-> rsp_payload.text_done)
      else $error("update summary without text end");

endmodule

bind servo_telemetry_range_capture stcr_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
